[sv/att_pkg.sv]
// att_pkg: types, constants and helper functions for the align-to-target rotation pipeline
// no dependencies; imported by align_to_target_rotation_top
`timescale 1ns / 1ps
`default_nettype none

package att_pkg;

    localparam int DATA_W        = 16;
    localparam int GUARD         = 14;  // guard bits of the target length
    localparam int FRAC_BITS_DEF = 14;
    localparam int SQ1_STEPS     = 30;  // root bits of |t| * 2^14
    localparam int DIV1_BITS     = 48;  // quotient bits of the projection term
    localparam int SQ2_STEPS     = 31;  // root bits of the normalized length
    localparam int NORM_W        = 30;  // width of a normalized magnitude
    localparam int NORM_LEAD     = 29;  // leading one position after normalizing
    localparam int MAG_W         = 62;  // width of a raw magnitude of w

    // case codes
    localparam logic [1:0] CASE_GENERAL  = 2'd0;
    localparam logic [1:0] CASE_ALIGNED  = 2'd1;
    localparam logic [1:0] CASE_OPPOSITE = 2'd2;
    localparam logic [1:0] CASE_DEGEN    = 2'd3;

    // item context through the front part of the pipeline
    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        logic        [31:0] s;     // tx^2 + ty^2
        logic signed [32:0] d;     // tx*px + ty*py
        logic signed [32:0] g;     // tz*pz - d
        logic        [1:0]  code;
    } ctx_t;

    // item context through the normalization part
    typedef struct packed {
        logic [2:0][NORM_W-1:0] a;
        logic [2:0]             neg;
        logic [1:0]             code;
    } nrm_t;

    // digit-by-digit square root state
    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
    } sqrt_state_t;

    // one root bit: try root + 2^bit_idx against the remainder
    function automatic sqrt_state_t sqrt_step(sqrt_state_t st, int unsigned bit_idx);
        logic [63:0] trial;
        sqrt_state_t res;
        trial = ({32'b0, st.root} << (bit_idx + 1)) + (64'd1 << (2 * bit_idx));
        res   = st;
        if (st.rem >= trial) begin
            res.rem  = st.rem - trial;
            res.root = st.root | (32'd1 << bit_idx);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/align_to_target_rotation_top.sv]
// align_to_target_rotation_top: pipelined rotation of a point by the turn taking z onto a target
// depends on att_pkg (types, case codes, square root step)
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata: point x,y,z, target x,y,z (16 bits each)
//  m_      | out | m_tvalid / m_tready  | m_tdata: out x,y,z (16 bits each); m_tuser: case code
//
// one item enters per cycle unless a result waits at m_; most of the pipeline depth is
// in the two bit-per-stage square roots, the 48-stage divider for the
// projection term and the FRAC_BITS+1-stage output dividers
// all stages advance together; a result held at m_ freezes the whole pipeline in place
// synchronous active-low reset clears the valid bits only
`timescale 1ns / 1ps
`default_nettype none

module align_to_target_rotation_top
    import att_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // point_x, point_y, point_z, target_x, target_y, target_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_x, out_y, out_z
    output logic [1:0]       m_tuser    // case_code
);

    localparam int QB   = FRAC_BITS + 1;           // output quotient bits
    localparam int NUMW = NORM_W + FRAC_BITS + 1;  // output dividend width

    logic en;
    logic m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    // whole pipeline moves unless a result waits
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- input register ----------------
    logic s0_v_reg;
    ctx_t s0_ctx_reg;
    ctx_t s0_ctx_next;

    always_comb begin
        s0_ctx_next    = '0;
        s0_ctx_next.px = s_tdata[15:0];
        s0_ctx_next.py = s_tdata[31:16];
        s0_ctx_next.pz = s_tdata[47:32];
        s0_ctx_next.tx = s_tdata[63:48];
        s0_ctx_next.ty = s_tdata[79:64];
        s0_ctx_next.tz = s_tdata[95:80];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg <= 1'b0;
        end else if (en) begin
            s0_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_ctx_reg <= s0_ctx_next;
        end
    end

    // ---------------- products ----------------
    logic s1_v_reg;
    ctx_t s1_ctx_reg;
    logic signed [31:0] s1_txx_reg, s1_tyy_reg, s1_tzz_reg;
    logic signed [31:0] s1_txpx_reg, s1_typy_reg, s1_tzpz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= s0_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ctx_reg  <= s0_ctx_reg;
            s1_txx_reg  <= s0_ctx_reg.tx * s0_ctx_reg.tx;
            s1_tyy_reg  <= s0_ctx_reg.ty * s0_ctx_reg.ty;
            s1_tzz_reg  <= s0_ctx_reg.tz * s0_ctx_reg.tz;
            s1_txpx_reg <= s0_ctx_reg.tx * s0_ctx_reg.px;
            s1_typy_reg <= s0_ctx_reg.ty * s0_ctx_reg.py;
            s1_tzpz_reg <= s0_ctx_reg.tz * s0_ctx_reg.pz;
        end
    end

    // ---------------- sums and case detection ----------------
    ctx_t        s2_ctx_next;
    logic [31:0] s2_t2_next;
    logic        s2_zp, s2_zt;

    always_comb begin
        s2_ctx_next   = s1_ctx_reg;
        s2_ctx_next.s = $unsigned(s1_txx_reg) + $unsigned(s1_tyy_reg);
        s2_t2_next    = s2_ctx_next.s + $unsigned(s1_tzz_reg);
        s2_ctx_next.d = 33'(s1_txpx_reg) + 33'(s1_typy_reg);
        s2_ctx_next.g = 33'(s1_tzpz_reg) - 33'(s1_txpx_reg) - 33'(s1_typy_reg);
        s2_zp = (s1_ctx_reg.px == '0) && (s1_ctx_reg.py == '0) && (s1_ctx_reg.pz == '0);
        s2_zt = (s1_ctx_reg.tx == '0) && (s1_ctx_reg.ty == '0) && (s1_ctx_reg.tz == '0);
        priority if (s2_zp || s2_zt) begin
            s2_ctx_next.code = CASE_DEGEN;
        end else if (s2_ctx_next.s == '0) begin
            s2_ctx_next.code = (s1_ctx_reg.tz > 0) ? CASE_ALIGNED : CASE_OPPOSITE;
        end else begin
            s2_ctx_next.code = CASE_GENERAL;
        end
    end

    // ---------------- square root of the target length ----------------
    logic [SQ1_STEPS:0] sq1_v_reg;
    ctx_t               sq1_ctx_reg [0:SQ1_STEPS];
    sqrt_state_t        sq1_st_reg  [0:SQ1_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq1_v_reg <= '0;
        end else if (en) begin
            sq1_v_reg <= {sq1_v_reg[SQ1_STEPS-1:0], s1_v_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq1_ctx_reg[0] <= s2_ctx_next;
            sq1_st_reg[0]  <= '{rem: {4'b0, s2_t2_next, 28'b0}, root: 32'd0};
        end
    end

    for (genvar k = 1; k <= SQ1_STEPS; k++) begin : g_sq1
        always_ff @(posedge aclk) begin
            if (en) begin
                sq1_ctx_reg[k] <= sq1_ctx_reg[k-1];
                sq1_st_reg[k]  <= sqrt_step(sq1_st_reg[k-1], SQ1_STEPS - k);
            end
        end
    end

    // ---------------- projection numerator ----------------
    logic               mr_v_reg, mu_v_reg;
    ctx_t               mr_ctx_reg, mu_ctx_reg;
    logic [29:0]        mr_lq_reg, mu_lq_reg;
    logic [30:0]        mr_m_reg;
    logic [31:0]        mr_dmag_reg;
    logic               mr_dneg_reg, mu_dneg_reg;
    logic [62:0]        mu_prod_reg;
    logic signed [31:0] mr_m_next;
    logic signed [32:0] mr_dmag_next;
    logic [29:0]        sq1_lq;

    assign sq1_lq = sq1_st_reg[SQ1_STEPS].root[29:0];

    // M = Lq - tz * 2^14, never negative in the general case
    always_comb begin
        mr_m_next    = $signed({2'b00, sq1_lq})
                     - ($signed(32'(sq1_ctx_reg[SQ1_STEPS].tz)) <<< GUARD);
        mr_dmag_next = sq1_ctx_reg[SQ1_STEPS].d[32] ? -sq1_ctx_reg[SQ1_STEPS].d
                                                    : sq1_ctx_reg[SQ1_STEPS].d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mr_v_reg <= 1'b0;
            mu_v_reg <= 1'b0;
        end else if (en) begin
            mr_v_reg <= sq1_v_reg[SQ1_STEPS];
            mu_v_reg <= mr_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mr_ctx_reg  <= sq1_ctx_reg[SQ1_STEPS];
            mr_lq_reg   <= sq1_lq;
            mr_m_reg    <= mr_m_next[30:0];
            mr_dmag_reg <= mr_dmag_next[31:0];
            mr_dneg_reg <= sq1_ctx_reg[SQ1_STEPS].d[32];
            mu_ctx_reg  <= mr_ctx_reg;
            mu_lq_reg   <= mr_lq_reg;
            mu_dneg_reg <= mr_dneg_reg;
            mu_prod_reg <= mr_dmag_reg * mr_m_reg;
        end
    end

    // ---------------- projection divider, one quotient bit a stage ----------------
    logic [DIV1_BITS:0] dv1_v_reg;
    ctx_t               dv1_ctx_reg  [0:DIV1_BITS];
    logic [29:0]        dv1_lq_reg   [0:DIV1_BITS];
    logic               dv1_dneg_reg [0:DIV1_BITS];
    logic [31:0]        dv1_rem_reg  [0:DIV1_BITS];
    logic [DIV1_BITS-1:0] dv1_lo_reg [0:DIV1_BITS];
    logic [DIV1_BITS-1:0] dv1_q_reg  [0:DIV1_BITS];
    logic [62:0]        dv1_num_next;

    assign dv1_num_next = mu_prod_reg + 63'(mu_ctx_reg.s >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv1_v_reg <= '0;
        end else if (en) begin
            dv1_v_reg <= {dv1_v_reg[DIV1_BITS-1:0], mu_v_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv1_ctx_reg[0]  <= mu_ctx_reg;
            dv1_lq_reg[0]   <= mu_lq_reg;
            dv1_dneg_reg[0] <= mu_dneg_reg;
            dv1_rem_reg[0]  <= 32'(dv1_num_next[62:DIV1_BITS]);
            dv1_lo_reg[0]   <= dv1_num_next[DIV1_BITS-1:0];
            dv1_q_reg[0]    <= '0;
        end
    end

    for (genvar k = 1; k <= DIV1_BITS; k++) begin : g_dv1
        logic [32:0] dv1_tmp;
        assign dv1_tmp = {dv1_rem_reg[k-1], dv1_lo_reg[k-1][DIV1_BITS-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                dv1_ctx_reg[k]  <= dv1_ctx_reg[k-1];
                dv1_lq_reg[k]   <= dv1_lq_reg[k-1];
                dv1_dneg_reg[k] <= dv1_dneg_reg[k-1];
                dv1_lo_reg[k]   <= {dv1_lo_reg[k-1][DIV1_BITS-2:0], 1'b0};
                if (dv1_tmp >= {1'b0, dv1_ctx_reg[k-1].s}) begin
                    dv1_rem_reg[k] <= 32'(dv1_tmp - {1'b0, dv1_ctx_reg[k-1].s});
                    dv1_q_reg[k]   <= {dv1_q_reg[k-1][DIV1_BITS-2:0], 1'b1};
                end else begin
                    dv1_rem_reg[k] <= dv1_tmp[31:0];
                    dv1_q_reg[k]   <= {dv1_q_reg[k-1][DIV1_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- rotated vector terms ----------------
    logic               pr_v_reg;
    ctx_t               pr_ctx_reg;
    logic               pr_dneg_reg;
    logic signed [46:0] pr_lqpx_reg, pr_lqpy_reg;
    logic signed [31:0] pr_txpz_reg, pr_typz_reg;
    logic signed [40:0] pr_txel_reg, pr_txeh_reg, pr_tyel_reg, pr_tyeh_reg;
    logic [DIV1_BITS-1:0] pr_e;
    ctx_t               pe_ctx;

    assign pr_e   = dv1_q_reg[DIV1_BITS];
    assign pe_ctx = dv1_ctx_reg[DIV1_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_v_reg <= 1'b0;
        end else if (en) begin
            pr_v_reg <= dv1_v_reg[DIV1_BITS];
        end
    end

    // E is split in two halves to keep each multiplier narrow
    always_ff @(posedge aclk) begin
        if (en) begin
            pr_ctx_reg  <= pe_ctx;
            pr_dneg_reg <= dv1_dneg_reg[DIV1_BITS];
            pr_lqpx_reg <= $signed({1'b0, dv1_lq_reg[DIV1_BITS]}) * pe_ctx.px;
            pr_lqpy_reg <= $signed({1'b0, dv1_lq_reg[DIV1_BITS]}) * pe_ctx.py;
            pr_txpz_reg <= pe_ctx.tx * pe_ctx.pz;
            pr_typz_reg <= pe_ctx.ty * pe_ctx.pz;
            pr_txel_reg <= pe_ctx.tx * $signed({1'b0, pr_e[23:0]});
            pr_txeh_reg <= pe_ctx.tx * $signed({1'b0, pr_e[47:24]});
            pr_tyel_reg <= pe_ctx.ty * $signed({1'b0, pr_e[23:0]});
            pr_tyeh_reg <= pe_ctx.ty * $signed({1'b0, pr_e[47:24]});
        end
    end

    // combine halves of t*E and apply the sign of D
    logic               w1_v_reg;
    ctx_t               w1_ctx_reg;
    logic signed [46:0] w1_lqpx_reg, w1_lqpy_reg;
    logic signed [31:0] w1_txpz_reg, w1_typz_reg;
    logic signed [63:0] w1_txe_reg, w1_tye_reg;
    logic signed [63:0] w1_txe_next, w1_tye_next;

    always_comb begin
        w1_txe_next = (64'(pr_txeh_reg) <<< 24) + 64'(pr_txel_reg);
        w1_tye_next = (64'(pr_tyeh_reg) <<< 24) + 64'(pr_tyel_reg);
        if (pr_dneg_reg) begin
            w1_txe_next = -w1_txe_next;
            w1_tye_next = -w1_tye_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w1_v_reg <= 1'b0;
        end else if (en) begin
            w1_v_reg <= pr_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w1_ctx_reg  <= pr_ctx_reg;
            w1_lqpx_reg <= pr_lqpx_reg;
            w1_lqpy_reg <= pr_lqpy_reg;
            w1_txpz_reg <= pr_txpz_reg;
            w1_typz_reg <= pr_typz_reg;
            w1_txe_reg  <= w1_txe_next;
            w1_tye_reg  <= w1_tye_next;
        end
    end

    // final w, with the special cases substituted
    logic                  w2_v_reg;
    logic [1:0]            w2_code_reg;
    logic signed [63:0]    w2_w_reg [0:2];
    logic signed [63:0]    w2_w_next [0:2];

    always_comb begin
        unique case (w1_ctx_reg.code)
            CASE_GENERAL: begin
                w2_w_next[0] = 64'(w1_lqpx_reg) + (64'(w1_txpz_reg) <<< GUARD) - w1_txe_reg;
                w2_w_next[1] = 64'(w1_lqpy_reg) + (64'(w1_typz_reg) <<< GUARD) - w1_tye_reg;
                w2_w_next[2] = 64'(w1_ctx_reg.g) <<< GUARD;
            end
            CASE_ALIGNED: begin
                w2_w_next[0] = 64'(w1_ctx_reg.px);
                w2_w_next[1] = 64'(w1_ctx_reg.py);
                w2_w_next[2] = 64'(w1_ctx_reg.pz);
            end
            CASE_OPPOSITE: begin
                w2_w_next[0] = -64'(w1_ctx_reg.px);
                w2_w_next[1] = 64'(w1_ctx_reg.py);
                w2_w_next[2] = -64'(w1_ctx_reg.pz);
            end
            default: begin
                w2_w_next[0] = '0;
                w2_w_next[1] = '0;
                w2_w_next[2] = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w2_v_reg <= 1'b0;
        end else if (en) begin
            w2_v_reg <= w1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w2_code_reg <= w1_ctx_reg.code;
            w2_w_reg    <= w2_w_next;
        end
    end

    // ---------------- magnitudes and signs ----------------
    logic                  n1_v_reg;
    logic [1:0]            n1_code_reg;
    logic [2:0][MAG_W-1:0] n1_a_reg;
    logic [2:0]            n1_neg_reg;
    logic [2:0][MAG_W-1:0] n1_a_next;
    logic [63:0]           n1_abs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_abs       = w2_w_reg[i][63] ? $unsigned(-w2_w_reg[i]) : $unsigned(w2_w_reg[i]);
            n1_a_next[i] = n1_abs[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_v_reg <= 1'b0;
        end else if (en) begin
            n1_v_reg <= w2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_a_reg    <= n1_a_next;
            n1_neg_reg  <= {w2_w_reg[2][63], w2_w_reg[1][63], w2_w_reg[0][63]};
            n1_code_reg <= (n1_a_next == '0) ? CASE_DEGEN : w2_code_reg;
        end
    end

    // largest magnitude
    logic                  n2_v_reg;
    logic [1:0]            n2_code_reg;
    logic [2:0][MAG_W-1:0] n2_a_reg;
    logic [2:0]            n2_neg_reg;
    logic [MAG_W-1:0]      n2_m_reg;
    logic [MAG_W-1:0]      n2_m01;

    assign n2_m01 = (n1_a_reg[0] >= n1_a_reg[1]) ? n1_a_reg[0] : n1_a_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n2_v_reg <= 1'b0;
        end else if (en) begin
            n2_v_reg <= n1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_a_reg    <= n1_a_reg;
            n2_neg_reg  <= n1_neg_reg;
            n2_code_reg <= n1_code_reg;
            n2_m_reg    <= (n2_m01 >= n1_a_reg[2]) ? n2_m01 : n1_a_reg[2];
        end
    end

    // leading one, first within each byte
    logic                  n3_v_reg;
    logic [1:0]            n3_code_reg;
    logic [2:0][MAG_W-1:0] n3_a_reg;
    logic [2:0]            n3_neg_reg;
    logic [7:0]            n3_nz_reg;
    logic [7:0][2:0]       n3_sub_reg;
    logic [7:0]            n3_nz_next;
    logic [7:0][2:0]       n3_sub_next;
    logic [63:0]           n3_m;

    always_comb begin
        n3_m = {2'b00, n2_m_reg};
        for (int b = 0; b < 8; b++) begin
            n3_nz_next[b]  = |n3_m[8*b +: 8];
            n3_sub_next[b] = '0;
            for (int j = 0; j < 8; j++) begin
                if (n3_m[8*b + j]) begin
                    n3_sub_next[b] = 3'(j);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n3_v_reg <= 1'b0;
        end else if (en) begin
            n3_v_reg <= n2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_a_reg    <= n2_a_reg;
            n3_neg_reg  <= n2_neg_reg;
            n3_code_reg <= n2_code_reg;
            n3_nz_reg   <= n3_nz_next;
            n3_sub_reg  <= n3_sub_next;
        end
    end

    // leading one, then across bytes
    logic                  n4_v_reg;
    logic [1:0]            n4_code_reg;
    logic [2:0][MAG_W-1:0] n4_a_reg;
    logic [2:0]            n4_neg_reg;
    logic [5:0]            n4_lead_reg;
    logic [5:0]            n4_lead_next;

    always_comb begin
        n4_lead_next = '0;
        for (int b = 0; b < 8; b++) begin
            if (n3_nz_reg[b]) begin
                n4_lead_next = {3'(b), n3_sub_reg[b]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n4_v_reg <= 1'b0;
        end else if (en) begin
            n4_v_reg <= n3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n4_a_reg    <= n3_a_reg;
            n4_neg_reg  <= n3_neg_reg;
            n4_code_reg <= n3_code_reg;
            n4_lead_reg <= n4_lead_next;
        end
    end

    // common shift putting the largest magnitude in [2^29, 2^30)
    logic n5_v_reg;
    nrm_t n5_nrm_reg;
    nrm_t n5_nrm_next;
    logic [MAG_W-1:0] n5_sh;

    always_comb begin
        n5_nrm_next.neg  = n4_neg_reg;
        n5_nrm_next.code = n4_code_reg;
        for (int i = 0; i < 3; i++) begin
            if (n4_lead_reg >= 6'(NORM_LEAD)) begin
                n5_sh = n4_a_reg[i] >> (n4_lead_reg - 6'(NORM_LEAD));
            end else begin
                n5_sh = n4_a_reg[i] << (6'(NORM_LEAD) - n4_lead_reg);
            end
            n5_nrm_next.a[i] = n5_sh[NORM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n5_v_reg <= 1'b0;
        end else if (en) begin
            n5_v_reg <= n4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n5_nrm_reg <= n5_nrm_next;
        end
    end

    // squares of the normalized magnitudes
    logic                     n6_v_reg;
    nrm_t                     n6_nrm_reg;
    logic [2:0][2*NORM_W-1:0] n6_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n6_v_reg <= 1'b0;
        end else if (en) begin
            n6_v_reg <= n5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n6_nrm_reg <= n5_nrm_reg;
            for (int i = 0; i < 3; i++) begin
                n6_sq_reg[i] <= n5_nrm_reg.a[i] * n5_nrm_reg.a[i];
            end
        end
    end

    // ---------------- square root of the length ----------------
    logic [SQ2_STEPS:0] sq2_v_reg;
    nrm_t               sq2_nrm_reg [0:SQ2_STEPS];
    sqrt_state_t        sq2_st_reg  [0:SQ2_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq2_v_reg <= '0;
        end else if (en) begin
            sq2_v_reg <= {sq2_v_reg[SQ2_STEPS-1:0], n6_v_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq2_nrm_reg[0] <= n6_nrm_reg;
            sq2_st_reg[0]  <= '{rem: 64'(n6_sq_reg[0]) + 64'(n6_sq_reg[1])
                                     + 64'(n6_sq_reg[2]),
                                root: 32'd0};
        end
    end

    for (genvar k = 1; k <= SQ2_STEPS; k++) begin : g_sq2
        always_ff @(posedge aclk) begin
            if (en) begin
                sq2_nrm_reg[k] <= sq2_nrm_reg[k-1];
                sq2_st_reg[k]  <= sqrt_step(sq2_st_reg[k-1], SQ2_STEPS - k);
            end
        end
    end

    // ---------------- output dividers, three lanes ----------------
    logic [QB:0]          dv2_v_reg;
    logic [2:0]           dv2_neg_reg  [0:QB];
    logic [1:0]           dv2_code_reg [0:QB];
    logic [30:0]          dv2_nr_reg   [0:QB];
    logic [2:0][30:0]     dv2_rem_reg  [0:QB];
    logic [2:0][QB-1:0]   dv2_lo_reg   [0:QB];
    logic [2:0][QB-1:0]   dv2_q_reg    [0:QB];
    logic [2:0][NUMW-1:0] dv2_num_next;
    logic [30:0]          dv2_nr;

    assign dv2_nr = sq2_st_reg[SQ2_STEPS].root[30:0];

    // dividend a * 2^FRAC_BITS + n/2 rounds to nearest
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv2_num_next[i] = {1'b0, sq2_nrm_reg[SQ2_STEPS].a[i], {FRAC_BITS{1'b0}}}
                            + NUMW'(dv2_nr >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv2_v_reg <= '0;
        end else if (en) begin
            dv2_v_reg <= {dv2_v_reg[QB-1:0], sq2_v_reg[SQ2_STEPS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv2_neg_reg[0]  <= sq2_nrm_reg[SQ2_STEPS].neg;
            dv2_code_reg[0] <= sq2_nrm_reg[SQ2_STEPS].code;
            dv2_nr_reg[0]   <= dv2_nr;
            for (int i = 0; i < 3; i++) begin
                dv2_rem_reg[0][i] <= 31'(dv2_num_next[i][NUMW-1:QB]);
                dv2_lo_reg[0][i]  <= dv2_num_next[i][QB-1:0];
                dv2_q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_dv2
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [31:0] dv2_tmp;
            assign dv2_tmp = {dv2_rem_reg[k-1][i], dv2_lo_reg[k-1][i][QB-1]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv2_lo_reg[k][i] <= {dv2_lo_reg[k-1][i][QB-2:0], 1'b0};
                    if (dv2_tmp >= {1'b0, dv2_nr_reg[k-1]}) begin
                        dv2_rem_reg[k][i] <= 31'(dv2_tmp - {1'b0, dv2_nr_reg[k-1]});
                        dv2_q_reg[k][i]   <= {dv2_q_reg[k-1][i][QB-2:0], 1'b1};
                    end else begin
                        dv2_rem_reg[k][i] <= dv2_tmp[30:0];
                        dv2_q_reg[k][i]   <= {dv2_q_reg[k-1][i][QB-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dv2_neg_reg[k]  <= dv2_neg_reg[k-1];
                dv2_code_reg[k] <= dv2_code_reg[k-1];
                dv2_nr_reg[k]   <= dv2_nr_reg[k-1];
            end
        end
    end

    // ---------------- output register ----------------
    logic [47:0] m_tdata_next;
    logic [31:0] out_val;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            out_val = 32'(dv2_q_reg[QB][i]);
            if (dv2_neg_reg[QB][i]) begin
                out_val = -out_val;
            end
            m_tdata_next[16*i +: 16] = (dv2_code_reg[QB] == CASE_DEGEN) ? 16'd0 : out_val[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv2_v_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= dv2_code_reg[QB];
        end
    end

endmodule

`default_nettype wire
